// ===== hdl/triangular_arbitrage_evaluator_top_macros.svh =====
// assertion macros for the triangular arbitrage evaluator
// used by tae_div and triangular_arbitrage_evaluator_top; expects clk and rst_n in scope
`ifndef TRIANGULAR_ARBITRAGE_EVALUATOR_TOP_MACROS_SVH
`define TRIANGULAR_ARBITRAGE_EVALUATOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define TAE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tae_pkg.sv =====
// shared constants for the triangular arbitrage evaluator
// no dependencies; used by tae_div and the top level
package tae_pkg;

  // quotient width of every divider
  localparam int QW = 64;

  // divider depth: one overflow check stage plus one stage per quotient bit
  localparam int DIV_LAT = QW + 1;

  // register index of the fee register
  localparam logic [0:0] REG_FEE = 1'b0;

  localparam int          FEE_W   = 20;
  localparam logic [19:0] FEE_RST = 20'd1000;
  localparam logic [19:0] PPM_ONE = 20'd1000000;

  // cube of the fee factor and its unit value 10^18
  localparam int          K3_W   = 60;
  localparam logic [31:0] E_LO   = 32'hA764_0000;
  localparam logic [31:0] E_HI   = 32'h0DE0_B6B3;

  // cross times base product width, and profit product width
  localparam int XB_W   = 128;
  localparam int PROD_W = XB_W + K3_W;

endpackage

// ===== hdl/triangular_arbitrage_evaluator_top.sv =====
// triangular arbitrage evaluator: one transaction per cycle, busy stays low.
// a result passes nine arithmetic stages, the 65-stage dividers and the output register.
// synchronous active-low reset clears the valid pipeline and sets fee_r to 1000.
// depends on tae_pkg, tae_div and triangular_arbitrage_evaluator_top_macros.svh
`include "triangular_arbitrage_evaluator_top_macros.svh"

module triangular_arbitrage_evaluator_top
  import tae_pkg::*;
#(
  parameter int PRICE_FRAC_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_base_price_b,
  input  logic [63:0] in_base_price_c,
  input  logic [63:0] in_cross_price,
  output logic        out_valid,
  output logic [63:0] out_fair_cross_price,
  output logic signed [63:0] out_deviation_percent,
  output logic signed [63:0] out_best_profit_percent,
  output logic        out_best_direction,
  output logic        out_price_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CS_W   = QW + PRICE_FRAC_BITS;
  localparam int DX_W   = XB_W + 7;
  localparam int PX_W   = PROD_W + 7;
  localparam int DVN_W  = DX_W + 32;
  localparam int PFN_W  = PX_W + 32;

  typedef struct packed {
    logic err;
    logic ccw;
    logic neg_dev;
  } side_t;

  // ---------------- configuration ----------------
  logic [FEE_W-1:0] fee_r;
  logic [FEE_W-1:0] k_r;
  logic             kz_r;
  logic [39:0]      kk_r;
  logic [K3_W-1:0]  k3_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_FEE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fee_r <= FEE_RST;
    end else if (cfg_wr) begin
      fee_r <= pwdata[FEE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == REG_FEE) begin
      prdata = 32'(fee_r);
    end
  end

  // fee factor k = 1 - fee (zero once fee reaches one) and its cube, registered through k_r, kk_r and k3_r
  always_ff @(posedge clk) begin
    k_r  <= (fee_r < PPM_ONE) ? (PPM_ONE - fee_r) : '0;
    kz_r <= (fee_r >= PPM_ONE);
    kk_r <= k_r * k_r;
    k3_r <= K3_W'(kk_r) * K3_W'(k_r);
  end

  // ---------------- stage 1: input capture ----------------
  logic        v1_r;
  logic [63:0] b1_r, c1_r, x1_r;
  logic        e1_r;

  always_ff @(posedge clk) begin
    b1_r <= in_base_price_b;
    c1_r <= in_base_price_c;
    x1_r <= in_cross_price;
    e1_r <= (in_base_price_b == '0) || (in_base_price_c == '0) || (in_cross_price == '0);
  end

  // ---------------- stage 2: cross times base partial products ----------------
  logic        v2_r;
  logic [63:0] b2_r, c2_r;
  logic        e2_r;
  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;

  always_ff @(posedge clk) begin
    b2_r   <= b1_r;
    c2_r   <= c1_r;
    e2_r   <= e1_r;
    pp00_r <= x1_r[31:0]  * b1_r[31:0];
    pp01_r <= x1_r[31:0]  * b1_r[63:32];
    pp10_r <= x1_r[63:32] * b1_r[31:0];
    pp11_r <= x1_r[63:32] * b1_r[63:32];
  end

  // ---------------- stage 3: product sum and scaled c ----------------
  logic            v3_r;
  logic [63:0]     b3_r;
  logic            e3_r;
  logic [XB_W-1:0] xb3_r;
  logic [CS_W-1:0] cs3_r;

  always_ff @(posedge clk) begin
    b3_r  <= b2_r;
    e3_r  <= e2_r;
    xb3_r <= XB_W'(pp00_r) + (XB_W'(pp01_r) << 32) + (XB_W'(pp10_r) << 32)
           + (XB_W'(pp11_r) << 64);
    cs3_r <= {c2_r, {PRICE_FRAC_BITS{1'b0}}};
  end

  // ---------------- stage 4: compare, cycle choice, deviation difference ----------------
  logic [XB_W-1:0] cs3_ext;
  logic            lt3;
  logic            cw3;

  assign cs3_ext = XB_W'(cs3_r);
  assign lt3     = (xb3_r < cs3_ext);
  assign cw3     = !kz_r && lt3;

  logic            v4_r;
  logic [63:0]     b4_r;
  logic [CS_W-1:0] cs4_r;
  side_t           sd4_r;
  logic [XB_W-1:0] dd4_r, a4_r, d4_r;

  always_ff @(posedge clk) begin
    b4_r          <= b3_r;
    cs4_r         <= cs3_r;
    sd4_r.err     <= e3_r;
    sd4_r.ccw     <= !cw3;
    sd4_r.neg_dev <= lt3;
    dd4_r         <= lt3 ? (cs3_ext - xb3_r) : (xb3_r - cs3_ext);
    a4_r          <= cw3 ? cs3_ext : xb3_r;
    d4_r          <= cw3 ? xb3_r : cs3_ext;
  end

  // ---------------- stage 5: profit partial products, deviation times 100 ----------------
  logic [63:0] k3_ext;
  logic [31:0] e_limb [0:1];

  assign k3_ext    = 64'(k3_r);
  assign e_limb[0] = E_LO;
  assign e_limb[1] = E_HI;

  logic            v5_r;
  logic [63:0]     b5_r;
  logic [CS_W-1:0] cs5_r;
  side_t           sd5_r;
  logic [DX_W-1:0] dx5_r;
  logic [63:0]     pk5_r [0:3][0:1];
  logic [63:0]     pe5_r [0:3][0:1];

  always_ff @(posedge clk) begin
    b5_r  <= b4_r;
    cs5_r <= cs4_r;
    sd5_r <= sd4_r;
    dx5_r <= (DX_W'(dd4_r) << 6) + (DX_W'(dd4_r) << 5) + (DX_W'(dd4_r) << 2);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        pk5_r[i][j] <= a4_r[32*i +: 32] * k3_ext[32*j +: 32];
        pe5_r[i][j] <= d4_r[32*i +: 32] * e_limb[j];
      end
    end
  end

  // ---------------- stage 6: row sums ----------------
  logic            v6_r;
  logic [63:0]     b6_r;
  logic [CS_W-1:0] cs6_r;
  side_t           sd6_r;
  logic [DX_W-1:0] dx6_r;
  logic [95:0]     rk6_r [0:3];
  logic [95:0]     re6_r [0:3];

  always_ff @(posedge clk) begin
    b6_r  <= b5_r;
    cs6_r <= cs5_r;
    sd6_r <= sd5_r;
    dx6_r <= dx5_r;
    for (int i = 0; i < 4; i++) begin
      rk6_r[i] <= 96'(pk5_r[i][0]) + {pk5_r[i][1], 32'b0};
      re6_r[i] <= 96'(pe5_r[i][0]) + {pe5_r[i][1], 32'b0};
    end
  end

  // ---------------- stage 7: full products ----------------
  logic              v7_r;
  logic [63:0]       b7_r;
  logic [CS_W-1:0]   cs7_r;
  side_t             sd7_r;
  logic [DX_W-1:0]   dx7_r;
  logic [PROD_W-1:0] ak7_r, de7_r;

  always_ff @(posedge clk) begin
    b7_r  <= b6_r;
    cs7_r <= cs6_r;
    sd7_r <= sd6_r;
    dx7_r <= dx6_r;
    ak7_r <= PROD_W'(rk6_r[0]) + (PROD_W'(rk6_r[1]) << 32)
           + (PROD_W'(rk6_r[2]) << 64) + (PROD_W'(rk6_r[3]) << 96);
    de7_r <= PROD_W'(re6_r[0]) + (PROD_W'(re6_r[1]) << 32)
           + (PROD_W'(re6_r[2]) << 64) + (PROD_W'(re6_r[3]) << 96);
  end

  // ---------------- stage 8: profit difference ----------------
  logic              lt7;
  assign lt7 = (ak7_r < de7_r);

  logic              v8_r;
  logic [63:0]       b8_r;
  logic [CS_W-1:0]   cs8_r;
  side_t             sd8_r;
  logic [DX_W-1:0]   dx8_r;
  logic              np8_r;
  logic [PROD_W-1:0] pd8_r, de8_r;

  always_ff @(posedge clk) begin
    b8_r  <= b7_r;
    cs8_r <= cs7_r;
    sd8_r <= sd7_r;
    dx8_r <= dx7_r;
    np8_r <= lt7;
    pd8_r <= lt7 ? (de7_r - ak7_r) : (ak7_r - de7_r);
    de8_r <= de7_r;
  end

  // ---------------- stage 9: profit difference times 100 ----------------
  logic              v9_r;
  logic [63:0]       b9_r;
  logic [CS_W-1:0]   cs9_r;
  side_t             sd9_r;
  logic [DX_W-1:0]   dx9_r;
  logic              np9_r;
  logic [PX_W-1:0]   px9_r;
  logic [PROD_W-1:0] de9_r;

  always_ff @(posedge clk) begin
    b9_r  <= b8_r;
    cs9_r <= cs8_r;
    sd9_r <= sd8_r;
    dx9_r <= dx8_r;
    np9_r <= np8_r;
    px9_r <= (PX_W'(pd8_r) << 6) + (PX_W'(pd8_r) << 5) + (PX_W'(pd8_r) << 2);
    de9_r <= de8_r;
  end

  // valid pipeline for the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // ---------------- dividers ----------------
  logic          fv, dv, pv;
  logic [QW-1:0] fq, dq, pq;
  logic          fs, ds, ps;
  logic          f_err;
  logic          d_neg;
  logic [1:0]    p_tag;

  // fair cross price: c * 2^F / b
  tae_div #(.NUM_W(CS_W), .DEN_W(64), .TAG_W(1)) u_div_fair (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v9_r),
    .num_i (cs9_r),
    .den_i (b9_r),
    .tag_i (sd9_r.err),
    .vld_o (fv),
    .q_o   (fq),
    .sat_o (fs),
    .tag_o (f_err)
  );

  // deviation: 100 * 2^32 * |xb - cs| / cs
  tae_div #(.NUM_W(DVN_W), .DEN_W(CS_W), .TAG_W(1)) u_div_dev (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v9_r),
    .num_i ({dx9_r, 32'b0}),
    .den_i (cs9_r),
    .tag_i (sd9_r.neg_dev),
    .vld_o (dv),
    .q_o   (dq),
    .sat_o (ds),
    .tag_o (d_neg)
  );

  // profit of the chosen cycle
  tae_div #(.NUM_W(PFN_W), .DEN_W(PROD_W), .TAG_W(2)) u_div_prof (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v9_r),
    .num_i ({px9_r, 32'b0}),
    .den_i (de9_r),
    .tag_i ({sd9_r.ccw, np9_r}),
    .vld_o (pv),
    .q_o   (pq),
    .sat_o (ps),
    .tag_o (p_tag)
  );

  // signed clamp of a magnitude quotient into Q31.32
  function automatic logic [63:0] pct_clamp(input logic [63:0] q, input logic sat,
                                            input logic neg);
    logic [63:0] r;
    if (!neg) begin
      r = (sat || q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q;
    end else begin
      r = (sat || (q > 64'h8000_0000_0000_0000)) ? 64'h8000_0000_0000_0000 : (64'd0 - q);
    end
    return r;
  endfunction

  // ---------------- output register ----------------
  logic        ov_r;
  logic [63:0] of_r, od_r, op_r;
  logic        odir_r, oerr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= fv && dv && pv;
    end
  end

  always_ff @(posedge clk) begin
    oerr_r <= f_err;
    if (f_err) begin
      of_r   <= '0;
      od_r   <= '0;
      op_r   <= '0;
      odir_r <= 1'b0;
    end else begin
      of_r   <= fs ? '1 : fq;
      od_r   <= pct_clamp(dq, ds, d_neg);
      op_r   <= pct_clamp(pq, ps, p_tag[0]);
      odir_r <= p_tag[1];
    end
  end

  assign out_valid               = ov_r;
  assign out_fair_cross_price    = of_r;
  assign out_deviation_percent   = od_r;
  assign out_best_profit_percent = op_r;
  assign out_best_direction      = odir_r;
  assign out_price_error         = oerr_r;

  // error transaction carries only zeros; clockwise choice means cross below fair
  `TAE_ASSERT_IMPL(a_err_zero, ov_r && oerr_r, (of_r == '0) && (od_r == '0) && (op_r == '0) && !odir_r, "error result with nonzero fields")
  `TAE_ASSERT_IMPL(a_cw_dev, ov_r && !oerr_r && !odir_r, od_r[63] || (od_r == '0), "clockwise choice with positive deviation")
  `TAE_ASSERT_NEXT(a_fee_wr, cfg_wr, fee_r == $past(pwdata[FEE_W-1:0]), "fee register write lost")

endmodule

// ===== hdl/tae_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturation flag
// depends on tae_pkg and triangular_arbitrage_evaluator_top_macros.svh
`include "triangular_arbitrage_evaluator_top_macros.svh"

module tae_div
  import tae_pkg::*;
#(
  parameter int NUM_W = 128,
  parameter int DEN_W = 64,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [QW-1:0]    q_o,
  output logic             sat_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int HI_W  = NUM_W - QW;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;

  logic             vld_r [0:QW];
  logic [DEN_W-1:0] rem_r [0:QW];
  logic [DEN_W-1:0] den_r [0:QW];
  logic [QW-1:0]    low_r [0:QW];
  logic [QW-1:0]    q_r   [0:QW];
  logic             sat_r [0:QW];
  logic [TAG_W-1:0] tag_r [0:QW];

  // overflow check: quotient fits in QW bits only if the upper part is below the divisor
  assign hi_ext  = CMP_W'(num_i[NUM_W-1:QW]);
  assign den_ext = CMP_W'(den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= hi_ext[DEN_W-1:0];
    den_r[0] <= den_i;
    low_r[0] <= num_i[QW-1:0];
    q_r[0]   <= '0;
    sat_r[0] <= (hi_ext >= den_ext);
    tag_r[0] <= tag_i;
  end

  // one restoring step per stage
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_r[s], low_r[s][QW-1]};
    assign ge    = (trial >= {1'b0, den_r[s]});
    assign diff  = trial - {1'b0, den_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den_r[s+1] <= den_r[s];
      low_r[s+1] <= {low_r[s][QW-2:0], 1'b0};
      q_r[s+1]   <= {q_r[s][QW-2:0], ge};
      sat_r[s+1] <= sat_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign vld_o = vld_r[QW];
  assign q_o   = q_r[QW];
  assign sat_o = sat_r[QW];
  assign tag_o = tag_r[QW];

  // remainder stays below the divisor at entry and exit, stages advance every cycle
  `TAE_ASSERT_IMPL(a_rem_in, vld_r[0] && !sat_r[0], rem_r[0] < den_r[0], "entry remainder not below divisor")
  `TAE_ASSERT_IMPL(a_rem_out, vld_r[QW] && !sat_r[QW], rem_r[QW] < den_r[QW], "final remainder not below divisor")
  `TAE_ASSERT_NEXT(a_flow, vld_r[QW-1], vld_r[QW], "divider stage dropped a transaction")

endmodule

// ===== tb/tb_triangular_arbitrage_evaluator_top.sv =====
// self-checking testbench for triangular_arbitrage_evaluator_top
// depends on tae_pkg and the rtl of the evaluator; a small scoreboard predicts every result
module tb_triangular_arbitrage_evaluator_top
  import tae_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [2:0] FEE_ADDR = 3'(REG_FEE) << 2;

  typedef bit [255:0] big_t;

  typedef struct packed {
    logic [63:0] fair;
    logic [63:0] deviation;
    logic [63:0] profit;
    logic        direction;
    logic        error;
  } arb_result_t;

  // predicts evaluator results and compares them in order
  class arb_scoreboard;
    logic [19:0]  fee;
    arb_result_t  pending[$];
    int           mismatches;
    int           errors;

    function new();
      fee = FEE_RST;
      mismatches = 0;
      errors = 0;
    endfunction

    function logic [63:0] sat_u64(big_t v);
      return (v[255:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
    endfunction

    // 100 * (p - m) / d in Q31.32, truncated toward zero, saturated
    function logic [63:0] percent_q32(big_t p, big_t m, big_t d);
      big_t        diff;
      logic [63:0] mag;
      bit          neg;
      neg  = p < m;
      diff = neg ? m - p : p - m;
      mag  = sat_u64((diff * (big_t'(100) << 32)) / d);
      if (!neg) return (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
      if (mag > 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return 64'd0 - mag;
    endfunction

    function arb_result_t evaluate(logic [63:0] b, logic [63:0] c, logic [63:0] x);
      arb_result_t r;
      big_t        k, k3, unit, cs, xb, p_cw, p_ccw;
      bit          cw;
      r = '0;
      if (b == 0 || c == 0 || x == 0) begin
        r.error = 1'b1;
        return r;
      end
      k    = (fee < PPM_ONE) ? big_t'(PPM_ONE - fee) : big_t'(0);
      k3   = k * k * k;
      unit = big_t'(64'd1000000000000000000);
      cs   = big_t'(c) << FRAC;
      xb   = big_t'(x) * big_t'(b);
      r.fair      = sat_u64(cs / big_t'(b));
      r.deviation = percent_q32(xb, cs, cs);
      p_cw  = percent_q32(cs * k3, xb * unit, xb * unit);
      p_ccw = percent_q32(xb * k3, cs * unit, cs * unit);
      cw = (k != 0) && (cs > xb);
      r.profit    = cw ? p_cw : p_ccw;
      r.direction = !cw;
      return r;
    endfunction

    function void note_input(logic [63:0] b, logic [63:0] c, logic [63:0] x);
      pending.insert(pending.size(), evaluate(b, c, x));
    endfunction

    function void check_result(arb_result_t got);
      arb_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: fair %h/%h dev %h/%h profit %h/%h dir %b/%b err %b/%b",
                   want.fair, got.fair, want.deviation, got.deviation, want.profit,
                   got.profit, want.direction, got.direction, want.error, got.error);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_base_price_b = '0;
  logic [63:0] in_base_price_c = '0;
  logic [63:0] in_cross_price = '0;
  logic        out_valid;
  logic [63:0] out_fair_cross_price;
  logic signed [63:0] out_deviation_percent;
  logic signed [63:0] out_best_profit_percent;
  logic        out_best_direction;
  logic        out_price_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  arb_scoreboard sb = new();
  bit            took;
  int            cycles;

  triangular_arbitrage_evaluator_top u_top (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // monitor: accepted transactions, results and fee writes
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_n) begin
      if (start && !busy) begin
        sb.note_input(in_base_price_b, in_base_price_c, in_cross_price);
        took = 1'b1;
      end
      if (out_valid)
        sb.check_result({out_fair_cross_price, out_deviation_percent,
                         out_best_profit_percent, out_best_direction, out_price_error});
      if (psel && penable && pwrite && pready && paddr == FEE_ADDR)
        sb.fee = pwdata[19:0];
    end
  end

  // one transaction; called and returns at a falling edge
  task automatic send_prices(logic [63:0] b, logic [63:0] c, logic [63:0] x);
    in_base_price_b = b;
    in_base_price_c = c;
    in_cross_price  = x;
    start = 1'b1;
    took  = 1'b0;
    do begin
      @(posedge clk);
      #1;
    end while (!took);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_fee(logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = FEE_ADDR;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // random prices: mostly consistent triangles near fair value, some small or zero prices, some raw noise
  task automatic random_prices(output logic [63:0] b, output logic [63:0] c,
                               output logic [63:0] x);
    logic [127:0] fair;
    int           kind;
    kind = $urandom_range(0, 99);
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    x = {$urandom, $urandom};
    if (kind < 60) begin
      b = (64'($urandom_range(1, 100000)) << 30) + 64'($urandom);
      c = (64'($urandom_range(1, 100000)) << 30) + 64'($urandom);
      fair = (128'(c) << FRAC) / 128'(b);
      x = fair[63:0] + 64'($signed($urandom_range(0, 2000)) - 1000) * fair[63:20];
      if (x == 0) x = 1;
    end else if (kind < 70) begin
      b = 64'($urandom_range(1, 255));
      x = 64'($urandom_range(1, 255));
    end else if (kind < 75) begin
      case ($urandom_range(0, 2))
        0: b = '0;
        1: c = '0;
        default: x = '0;
      endcase
    end
  endtask

  // random bursts with random gaps; one pause for a full drain midway
  task automatic random_phase(int n);
    logic [63:0] b, c, x;
    int          sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < n) begin
        random_prices(b, c, x);
        send_prices(b, c, x);
        burst--;
        sent++;
        if (sent == n / 2) drain_results();
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] UNIT = 64'd1 << FRAC;

  initial begin
    logic [31:0] fees[5];
    fees = '{32'd0, 32'd999999, 32'hFFFFF, 32'd2500, 32'd1000};
    cycles = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: zero prices, extremes, ties, saturation, at reset fee
    send_prices(0, UNIT, UNIT);
    send_prices(UNIT, 0, UNIT);
    send_prices(UNIT, UNIT, 0);
    send_prices(0, 0, 0);
    send_prices(UNIT, UNIT, UNIT);
    send_prices(ALL1, ALL1, ALL1);
    send_prices(1, 1, 1);
    send_prices(1, ALL1, 1);
    send_prices(1, ALL1, ALL1);
    send_prices(ALL1, 1, 1);
    send_prices(ALL1, 1, ALL1);
    send_prices(UNIT * 2, UNIT * 6, UNIT * 3);
    send_prices(UNIT * 2, UNIT * 6, UNIT * 3 + 1);
    send_prices(UNIT * 2, UNIT * 6, UNIT * 3 - 1);
    send_prices(UNIT * 3, UNIT, UNIT / 3);
    send_prices(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    idle_cycles(3);
    send_prices(64'h0000_0100_0000_0000, 64'hFFFF_FF00_0000_0000, 64'd7);
    random_phase(400);

    // fee settings including zero fee, a fee just below one whole unit and one beyond it
    foreach (fees[i]) begin
      drain_results();
      write_fee(fees[i]);
      send_prices(UNIT * 2, UNIT * 6, UNIT * 3);
      send_prices(UNIT, UNIT * 5, UNIT * 5 + 64'd1000);
      send_prices(1, ALL1, ALL1);
      random_phase(320);
    end
    drain_results();
    write_fee($urandom_range(0, 999999));

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tae_pkg.sv
hdl/tae_div.sv
hdl/triangular_arbitrage_evaluator_top.sv
tb/tb_triangular_arbitrage_evaluator_top.sv
